// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent in one cycle implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// ===== src/pht_pkg.sv =====
package pht_pkg;

  localparam int NUM_SEQUENCES = 16;
  localparam int SEQ_LEN       = 1024;
  localparam int ROW_W         = $clog2(NUM_SEQUENCES);
  localparam int COL_W         = $clog2(SEQ_LEN);
  localparam int ADDR_W        = ROW_W + COL_W;

  localparam int OP_W     = 3;
  localparam int LEN_W    = 11;
  localparam int LEVEL_W  = 24;
  localparam int RETAIN_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int WFRAC_W  = 8;
  localparam int PROD_W   = WEIGHT_W + LEN_W;
  localparam int DVD_W    = PROD_W + WFRAC_W;
  localparam int DCNT_W   = $clog2(DVD_W);

  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REGIDX_W = PADDR_W - 2;

  localparam logic [REGIDX_W-1:0] REG_RETAIN_FACTOR = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_INIT_LEVEL    = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_MIN_LEVEL     = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_MAX_LEVEL     = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_BEST_WEIGHT   = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_ITER_WEIGHT   = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_FILL          = 3'd0,
    OP_EVAPORATE     = 3'd1,
    OP_START_DEPOSIT = 3'd2,
    OP_DEPOSIT_POINT = 3'd3,
    OP_READ          = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_EVAP,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_INC,
    ST_DEP_RD,
    ST_DEP_WR,
    ST_RD,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic [RETAIN_W-1:0] retain_factor;
    logic [LEVEL_W-1:0]  init_level;
    logic [LEVEL_W-1:0]  min_level;
    logic [LEVEL_W-1:0]  max_level;
    logic [WEIGHT_W-1:0] best_weight;
    logic [WEIGHT_W-1:0] iter_weight;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic sweep_clr;
    logic fill_wr;
    logic evap_rd;
    logic mul_load;
    logic div_step;
    logic inc_load;
    logic dep_rd;
    logic dep_wr;
    logic rd_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic evap_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/pht_if.sv =====
interface pht_req_if;
  logic                        valid;
  logic                        ready;
  logic [pht_pkg::OP_W-1:0]    op;
  logic [pht_pkg::ROW_W-1:0]   sequence_index;
  logic [pht_pkg::COL_W-1:0]   position;
  logic [pht_pkg::LEN_W-1:0]   solution_length;
  logic [pht_pkg::LEN_W-1:0]   upper_bound;
  logic                        use_best;

  modport source (output valid, op, sequence_index, position, solution_length, upper_bound,
                  use_best, input ready);
  modport sink (input valid, op, sequence_index, position, solution_length, upper_bound,
                use_best, output ready);
endinterface

interface pht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pht_pkg::LEVEL_W-1:0]  level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

// ===== src/pht_ram.sv =====
module pht_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/pht_datapath.sv =====
module pht_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  pht_pkg::cmd_t               cmd,
  output pht_pkg::sts_t               sts,
  input  pht_pkg::cfg_t               cfg,
  input  logic [pht_pkg::ROW_W-1:0]   sequence_index,
  input  logic [pht_pkg::COL_W-1:0]   position,
  input  logic [pht_pkg::LEN_W-1:0]   solution_length,
  input  logic [pht_pkg::LEN_W-1:0]   upper_bound,
  input  logic                        use_best,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pht_pkg::LEVEL_W-1:0] level
);
  import pht_pkg::*;

  logic [ADDR_W-1:0]   item_addr;
  logic [LEN_W-1:0]    item_len;
  logic [LEN_W-1:0]    item_ub;
  logic                item_sel;

  logic [ADDR_W-1:0]   sweep_addr;

  logic [DVD_W-1:0]    quo;
  logic [LEN_W-1:0]    rem;
  logic [DCNT_W-1:0]   div_cnt;
  logic [LEVEL_W-1:0]  increment;

  logic                v1, v2;
  logic [ADDR_W-1:0]   a1, a2;
  logic [LEVEL_W-1:0]  evap_scaled;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [LEVEL_W-1:0]  ram_wdata, ram_rdata;

  logic [LEN_W-1:0]    ub_eff, lenm1;
  logic [WEIGHT_W-1:0] weight;
  logic [PROD_W-1:0]   prod;
  logic [LEN_W:0]      rem_sh, rem_sub;
  logic                ge;
  logic [RETAIN_W+LEVEL_W-1:0] evap_prod;
  logic [LEVEL_W-1:0]  evap_val, dep_val;
  logic [LEVEL_W:0]    dep_sum;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_addr <= {sequence_index, position};
      item_len  <= solution_length;
      item_ub   <= upper_bound;
      item_sel  <= use_best;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      sweep_addr <= '0;
    end else if (cmd.fill_wr || cmd.evap_rd) begin
      sweep_addr <= sweep_addr + ADDR_W'(1);
    end
  end

  // increment = weight * (len - 1) * 2^8 / ub, one quotient bit a cycle
  always_comb begin
    ub_eff  = (item_ub == '0) ? LEN_W'(1) : item_ub;
    lenm1   = (item_len == '0) ? '0 : item_len - LEN_W'(1);
    weight  = item_sel ? cfg.best_weight : cfg.iter_weight;
    prod    = PROD_W'(weight) * PROD_W'(lenm1);
    rem_sh  = {rem, quo[DVD_W-1]};
    ge      = rem_sh >= {1'b0, ub_eff};
    rem_sub = rem_sh - {1'b0, ub_eff};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      quo     <= {prod, {WFRAC_W{1'b0}}};
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= {quo[DVD_W-2:0], ge};
      rem     <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      increment <= '0;
    end else if (cmd.inc_load) begin
      increment <= (|quo[DVD_W-1:LEVEL_W]) ? '1 : quo[LEVEL_W-1:0];
    end
  end

  // evaporate pipeline: table read, scale, clamp and write back
  always_comb begin
    evap_prod = (RETAIN_W+LEVEL_W)'(cfg.retain_factor) * (RETAIN_W+LEVEL_W)'(ram_rdata);
    evap_val  = (evap_scaled > cfg.min_level) ? evap_scaled : cfg.min_level;
    dep_sum   = {1'b0, ram_rdata} + {1'b0, increment};
    dep_val   = (dep_sum > {1'b0, cfg.max_level}) ? cfg.max_level : dep_sum[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.evap_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a1          <= sweep_addr;
    a2          <= a1;
    evap_scaled <= evap_prod[RETAIN_W+LEVEL_W-1:RETAIN_W];
  end

  always_comb begin
    ram_re    = cmd.evap_rd || cmd.dep_rd || cmd.rd_rd;
    ram_raddr = cmd.evap_rd ? sweep_addr : item_addr;
    ram_we    = cmd.fill_wr || v2 || cmd.dep_wr;
    if (cmd.fill_wr) begin
      ram_waddr = sweep_addr;
      ram_wdata = cfg.init_level;
    end else if (v2) begin
      ram_waddr = a2;
      ram_wdata = evap_val;
    end else begin
      ram_waddr = item_addr;
      ram_wdata = dep_val;
    end
  end

  pht_ram #(
    .DATA_W(LEVEL_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level <= ram_rdata;
    end
  end

  always_comb begin
    sts.sweep_last = &sweep_addr;
    sts.evap_busy  = v1 || v2;
    sts.div_done   = div_cnt == DCNT_W'(DVD_W - 1);
    sts.out_free   = !out_valid || out_ready;
  end
endmodule

// ===== src/pht_ctrl.sv =====
module pht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  pht_pkg::op_t  op,
  output logic          in_ready,
  output pht_pkg::cmd_t cmd,
  input  pht_pkg::sts_t sts
);
  import pht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_FILL:          state_next = ST_FILL;
            OP_EVAPORATE:     state_next = ST_EVAP;
            OP_START_DEPOSIT: state_next = ST_MUL;
            OP_DEPOSIT_POINT: state_next = ST_DEP_RD;
            OP_READ:          state_next = ST_RD;
            default:          state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL:   if (sts.sweep_last) state_next = ST_IDLE;
      ST_EVAP:   if (sts.sweep_last) state_next = ST_DRAIN;
      ST_DRAIN:  if (!sts.evap_busy) state_next = ST_IDLE;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (sts.div_done) state_next = ST_INC;
      ST_INC:    state_next = ST_IDLE;
      ST_DEP_RD: state_next = ST_DEP_WR;
      ST_DEP_WR: state_next = ST_IDLE;
      ST_RD:     state_next = ST_RD_OUT;
      ST_RD_OUT: if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        cmd.sweep_clr = in_valid;
      end
      ST_FILL:   cmd.fill_wr  = 1'b1;
      ST_EVAP:   cmd.evap_rd  = 1'b1;
      ST_MUL:    cmd.mul_load = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_INC:    cmd.inc_load = 1'b1;
      ST_DEP_RD: cmd.dep_rd   = 1'b1;
      ST_DEP_WR: cmd.dep_wr   = 1'b1;
      ST_RD:     cmd.rd_rd    = 1'b1;
      ST_RD_OUT: cmd.out_load = sts.out_free;
      default:   cmd          = '0;
    endcase
  end
endmodule

// ===== src/pheromone_table_update.sv =====
// Pheromone table of 16 x 1024 Q8.16 levels held in one memory with a write port and a
// registered read port. Items are taken one at a time. Read is a memory read, then an output
// load; deposit point is a memory read, then a read-modify-write of the clamped sum. Start
// deposit runs the bit-serial divider that produces one quotient bit per cycle over 35 bits.
// Fill and evaporate sweep the table, one table entry per cycle through the memory ports. A
// read result sits in an output register, so the next item is taken while it waits.
// The table is undefined after reset until the first fill.
`include "assert_macros.svh"

module pheromone_table_update (
  input  logic                        clk,
  input  logic                        rst,
  pht_req_if.sink                     req,
  pht_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pht_pkg::PADDR_W-1:0] paddr,
  input  logic [pht_pkg::PDATA_W-1:0] pwdata,
  output logic [pht_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pht_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic [REGIDX_W-1:0] reg_idx;
  logic [4:0] mem_cmds;
  logic req_xfer;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retain_factor <= RETAIN_W'(58982);
      cfg.init_level    <= LEVEL_W'(65536);
      cfg.min_level     <= LEVEL_W'(655);
      cfg.max_level     <= '1;
      cfg.best_weight   <= WEIGHT_W'(256);
      cfg.iter_weight   <= WEIGHT_W'(256);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_RETAIN_FACTOR: cfg.retain_factor <= pwdata[RETAIN_W-1:0];
        REG_INIT_LEVEL:    cfg.init_level    <= pwdata[LEVEL_W-1:0];
        REG_MIN_LEVEL:     cfg.min_level     <= pwdata[LEVEL_W-1:0];
        REG_MAX_LEVEL:     cfg.max_level     <= pwdata[LEVEL_W-1:0];
        REG_BEST_WEIGHT:   cfg.best_weight   <= pwdata[WEIGHT_W-1:0];
        REG_ITER_WEIGHT:   cfg.iter_weight   <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RETAIN_FACTOR: prdata = PDATA_W'(cfg.retain_factor);
      REG_INIT_LEVEL:    prdata = PDATA_W'(cfg.init_level);
      REG_MIN_LEVEL:     prdata = PDATA_W'(cfg.min_level);
      REG_MAX_LEVEL:     prdata = PDATA_W'(cfg.max_level);
      REG_BEST_WEIGHT:   prdata = PDATA_W'(cfg.best_weight);
      REG_ITER_WEIGHT:   prdata = PDATA_W'(cfg.iter_weight);
      default:           prdata = '0;
    endcase
  end

  pht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .op      (op_t'(req.op)),
    .in_ready(req.ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  pht_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .sequence_index (req.sequence_index),
    .position       (req.position),
    .solution_length(req.solution_length),
    .upper_bound    (req.upper_bound),
    .use_best       (req.use_best),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .level          (rsp.level)
  );

  assign mem_cmds = {cmd.fill_wr, cmd.evap_rd, cmd.dep_rd, cmd.dep_wr, cmd.rd_rd};
  assign req_xfer = req.valid && req.ready;

  `ASSERT_RST(a_mem_cmd_excl, clk, rst, $onehot0(mem_cmds), "table access commands overlap")
  `ASSERT_RST(a_accept_drained, clk, rst, req_xfer |-> !sts.evap_busy, "transfer during drain")
  `ASSERT_RST(a_out_load_free, clk, rst, cmd.out_load |-> sts.out_free, "result overwritten")
  `ASSERT_NEXT(a_dep_rmw, clk, rst, cmd.dep_rd, cmd.dep_wr, "deposit read not followed by write")
endmodule

// ===== tb/sv/pht_level_checker.sv =====
`timescale 1ns / 100ps

module pht_level_checker (
  input  logic                        clk,
  input  logic                        rst,
  pht_req_if                          item_ch,
  pht_rsp_if                          level_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pht_pkg::PADDR_W-1:0] paddr,
  input  logic [pht_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          levels_due
);
  import pht_pkg::*;

  localparam int TABLE_DEPTH = NUM_SEQUENCES * SEQ_LEN;
  localparam int REPORT_CAP  = 200;
  localparam logic [LEVEL_W-1:0] LEVEL_SAT = '1;
  localparam cfg_t CFG_RESET = '{
    retain_factor: 16'd58982,
    init_level:    24'd65536,
    min_level:     24'd655,
    max_level:     24'hFFFFFF,
    best_weight:   16'd256,
    iter_weight:   16'd256
  };

  cfg_t               cfg = CFG_RESET;
  logic [LEVEL_W-1:0] level_mirror [TABLE_DEPTH];
  logic [LEVEL_W-1:0] deposit_amount = '0;
  logic [LEVEL_W-1:0] levels_expected [$];
  logic [LEVEL_W-1:0] level_due;
  int                 error_total = 0;

  // weight * (length - 1) / bound, weight in Q8.8 so shift up to Q8.16
  function automatic logic [LEVEL_W-1:0] deposit_increment(
    input logic [WEIGHT_W-1:0] weight,
    input logic [LEN_W-1:0]    length,
    input logic [LEN_W-1:0]    bound
  );
    logic [63:0] divisor;
    logic [63:0] quotient;
    if (length == '0) return '0;
    divisor  = (bound == '0) ? 64'd1 : 64'(bound);
    quotient = ((64'(weight) * (64'(length) - 64'd1)) << WFRAC_W) / divisor;
    return (quotient > 64'(LEVEL_SAT)) ? LEVEL_SAT : quotient[LEVEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (error_total < REPORT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    error_total++;
  endtask

  task automatic apply_item();
    logic [ADDR_W-1:0]           addr;
    logic [LEVEL_W+RETAIN_W-1:0] scaled;
    logic [LEVEL_W:0]            summed;
    addr = {item_ch.sequence_index, item_ch.position};
    case (item_ch.op)
      OP_FILL: begin
        for (int i = 0; i < TABLE_DEPTH; i++) level_mirror[i] = cfg.init_level;
      end
      OP_EVAPORATE: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          scaled = (cfg.retain_factor * level_mirror[i]) >> RETAIN_W;
          level_mirror[i] = (scaled > cfg.min_level) ? scaled[LEVEL_W-1:0] : cfg.min_level;
        end
      end
      OP_START_DEPOSIT: begin
        deposit_amount = deposit_increment(
          item_ch.use_best ? cfg.best_weight : cfg.iter_weight,
          item_ch.solution_length, item_ch.upper_bound);
      end
      OP_DEPOSIT_POINT: begin
        summed = level_mirror[addr] + deposit_amount;
        level_mirror[addr] = (summed > cfg.max_level) ? cfg.max_level : summed[LEVEL_W-1:0];
      end
      OP_READ: begin
        levels_expected.push_back(level_mirror[addr]);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = CFG_RESET;
      deposit_amount = '0;
      levels_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_RETAIN_FACTOR: cfg.retain_factor = pwdata[RETAIN_W-1:0];
          REG_INIT_LEVEL:    cfg.init_level    = pwdata[LEVEL_W-1:0];
          REG_MIN_LEVEL:     cfg.min_level     = pwdata[LEVEL_W-1:0];
          REG_MAX_LEVEL:     cfg.max_level     = pwdata[LEVEL_W-1:0];
          REG_BEST_WEIGHT:   cfg.best_weight   = pwdata[WEIGHT_W-1:0];
          REG_ITER_WEIGHT:   cfg.iter_weight   = pwdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      // a level leaving now can only belong to a read taken at an earlier edge
      if (level_ch.valid && level_ch.ready) begin
        if (levels_expected.size() == 0) begin
          report_mismatch($sformatf("level 0x%06h with no read outstanding", level_ch.level));
        end else begin
          level_due = levels_expected.pop_front();
          if (level_ch.level !== level_due) begin
            report_mismatch($sformatf("level 0x%06h, expected 0x%06h",
                                      level_ch.level, level_due));
          end
        end
      end
      if (item_ch.valid && item_ch.ready) apply_item();
    end
    mismatches <= error_total;
    levels_due <= levels_expected.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pht_pkg::*;

  localparam int SWEEP_WAIT       = 16500;
  localparam int WATCHDOG_LIMIT   = 100000;
  localparam int RANDOM_PER_PHASE = 370;
  localparam int IDLE_PCT         = 47;
  localparam int BOTH_PCT         = 32;
  localparam int MAX_PATH         = 8;
  localparam logic [OP_W-1:0] OP_LAST = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  int                 mismatches;
  int                 levels_due;

  pht_req_if item_ch ();
  pht_rsp_if level_ch ();

  pheromone_table_update i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (item_ch),
    .rsp     (level_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pht_level_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .item_ch    (item_ch),
    .level_ch   (level_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .levels_due (levels_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    level_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      level_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (level_ch.valid && level_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? IDLE_PCT : (mode == IDLE_BOTH) ? BOTH_PCT : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? IDLE_PCT : (mode == IDLE_BOTH) ? BOTH_PCT : 0;
  endtask

  function automatic logic [LEN_W-1:0] rand_length();
    case ($urandom_range(3))
      0: return LEN_W'($urandom_range(40));
      1: return LEN_W'($urandom_range(SEQ_LEN + 1));
      2: return $urandom_range(1) ? LEN_W'(SEQ_LEN) : LEN_W'(SEQ_LEN + 1);
      default: return LEN_W'($urandom_range(1));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] rand_bound();
    if ($urandom_range(7) == 0) return LEN_W'($urandom_range(1));
    return LEN_W'($urandom_range(SEQ_LEN));
  endfunction

  task automatic send_item(
    input logic [OP_W-1:0]  op_code,
    input logic [ROW_W-1:0] row,
    input logic [COL_W-1:0] col,
    input logic [LEN_W-1:0] length,
    input logic [LEN_W-1:0] bound,
    input logic             pick_best
  );
    if ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.op              <= op_code;
    item_ch.sequence_index  <= row;
    item_ch.position        <= col;
    item_ch.solution_length <= length;
    item_ch.upper_bound     <= bound;
    item_ch.use_best        <= pick_best;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_random_fields(input logic [OP_W-1:0] op_code);
    send_item(op_code, ROW_W'($urandom), COL_W'($urandom), rand_length(), rand_bound(),
              1'($urandom));
  endtask

  task automatic wait_levels_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (levels_due != 0);
  endtask

  task automatic write_register(input logic [REGIDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // a sweep may still be running with nothing outstanding, so let it finish first
  task automatic load_settings(
    input logic [PDATA_W-1:0] retain,
    input logic [PDATA_W-1:0] init,
    input logic [PDATA_W-1:0] floor_level,
    input logic [PDATA_W-1:0] cap_level,
    input logic [PDATA_W-1:0] best,
    input logic [PDATA_W-1:0] iter
  );
    wait_levels_drained();
    repeat (SWEEP_WAIT) @(posedge clk);
    write_register(REG_RETAIN_FACTOR, retain);
    write_register(REG_INIT_LEVEL, init);
    write_register(REG_MIN_LEVEL, floor_level);
    write_register(REG_MAX_LEVEL, cap_level);
    write_register(REG_BEST_WEIGHT, best);
    write_register(REG_ITER_WEIGHT, iter);
  endtask

  task automatic run_directed();
    send_random_fields(OP_FILL);
    send_item(OP_READ, '0, '0, '0, '0, 1'b0);
    send_item(OP_READ, '1, '1, '1, '1, 1'b1);
    // empty solution gives a zero increment
    send_item(OP_START_DEPOSIT, '0, '0, '0, LEN_W'(SEQ_LEN), 1'b1);
    send_item(OP_DEPOSIT_POINT, '0, '0, '0, '0, 1'b0);
    send_item(OP_READ, '0, '0, '0, '0, 1'b0);
    // saturated increment, then the deposit hits the cap
    send_item(OP_START_DEPOSIT, '0, '0, LEN_W'(SEQ_LEN + 1), LEN_W'(1), 1'b0);
    send_item(OP_DEPOSIT_POINT, '1, '1, '1, '1, 1'b1);
    send_item(OP_READ, '1, '1, '0, '0, 1'b0);
    // zero bound behaves as a bound of one
    send_item(OP_START_DEPOSIT, '1, '1, LEN_W'(SEQ_LEN + 1), '0, 1'b1);
    send_item(OP_START_DEPOSIT, '0, '0, LEN_W'(11), LEN_W'(SEQ_LEN), 1'b0);
    send_item(OP_DEPOSIT_POINT, ROW_W'(7), COL_W'(512), '0, '0, 1'b0);
    send_item(OP_DEPOSIT_POINT, ROW_W'(7), COL_W'(512), '0, '0, 1'b0);
    send_item(OP_READ, ROW_W'(7), COL_W'(512), '0, '0, 1'b0);
    send_random_fields(OP_EVAPORATE);
    send_item(OP_READ, '0, '0, '0, '0, 1'b0);
    send_item(OP_READ, '1, '1, '0, '0, 1'b0);
    send_item(OP_READ, ROW_W'(7), COL_W'(512), '0, '0, 1'b0);
    for (int k = OP_READ + 1; k <= OP_LAST; k++) begin
      send_item(OP_W'(k), '1, '1, '1, '1, 1'b1);
    end
    send_item(OP_READ, ROW_W'(8), COL_W'(511), '1, '1, 1'b1);
  endtask

  task automatic run_random(input int item_goal, input bit mix_modes);
    logic [ROW_W-1:0] path_row [MAX_PATH];
    logic [COL_W-1:0] path_col [MAX_PATH];
    logic [COL_W-1:0] col;
    logic [OP_W-1:0]  op_code;
    int               sent;
    int               steps;
    int               checks;
    int               pick;
    sent = 0;
    while (sent < item_goal) begin
      if (mix_modes) set_idling(idle_mode_t'($urandom_range(3)));
      if ($urandom_range(99) < 70) begin
        // one solution: set the increment, lay it along a path, read some of it back
        steps = $urandom_range(1, MAX_PATH);
        send_random_fields(OP_START_DEPOSIT);
        col = COL_W'($urandom);
        for (int k = 0; k < steps; k++) begin
          col = col + COL_W'($urandom_range(1, 64));
          path_row[k] = ROW_W'($urandom);
          path_col[k] = col;
          send_item(OP_DEPOSIT_POINT, path_row[k], path_col[k], rand_length(), rand_bound(),
                    1'($urandom));
        end
        checks = $urandom_range(1, steps);
        for (int k = 0; k < checks; k++) begin
          send_item(OP_READ, path_row[k], path_col[k], rand_length(), rand_bound(),
                    1'($urandom));
        end
        sent += 1 + steps + checks;
      end else begin
        pick = $urandom_range(99);
        if (pick < 6) op_code = OP_FILL;
        else if (pick < 12) op_code = OP_EVAPORATE;
        else if (pick < 40) op_code = OP_READ;
        else if (pick < 65) op_code = OP_DEPOSIT_POINT;
        else if (pick < 85) op_code = OP_START_DEPOSIT;
        else op_code = OP_W'($urandom_range(OP_READ + 1, OP_LAST));
        send_random_fields(op_code);
        if (op_code <= OP_READ) sent++;
      end
      if ($urandom_range(99) < 2) wait_levels_drained();
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    item_ch.valid           <= 1'b0;
    item_ch.op              <= OP_FILL;
    item_ch.sequence_index  <= '0;
    item_ch.position        <= '0;
    item_ch.solution_length <= '0;
    item_ch.upper_bound     <= '0;
    item_ch.use_best        <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    run_directed();
    wait_levels_drained();

    load_settings(32'd65535, 32'hFFFFFF, 32'd0, 32'hFFFFFF, 32'd65535, 32'd0);
    set_idling(IDLE_NONE);
    run_random(RANDOM_PER_PHASE, 1'b0);

    load_settings(32'd0, 32'd0, 32'hFFFFFF, 32'd0, 32'd0, 32'd65535);
    set_idling(IDLE_SENDER);
    run_random(RANDOM_PER_PHASE, 1'b0);

    // tight band so both clamps trigger often
    load_settings(32'd32768, 32'd65536, 32'd1000, 32'd200000, 32'd256, 32'd128);
    set_idling(IDLE_RECEIVER);
    run_random(RANDOM_PER_PHASE, 1'b0);

    load_settings($urandom_range(65535), $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                  $urandom_range(24'hFFFFFF), $urandom_range(65535), $urandom_range(65535));
    set_idling(IDLE_BOTH);
    run_random(RANDOM_PER_PHASE, 1'b0);

    load_settings($urandom_range(65535), $urandom_range(24'h3FFFF), $urandom_range(24'h3FFF),
                  $urandom_range(24'h80000, 24'hFFFFFF), $urandom_range(1024),
                  $urandom_range(1024));
    run_random(RANDOM_PER_PHASE, 1'b1);

    wait_levels_drained();
    repeat (SWEEP_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pht_pkg.sv
src/pht_if.sv
src/pht_ram.sv
src/pht_datapath.sv
src/pht_ctrl.sv
src/pheromone_table_update.sv
tb/sv/pht_level_checker.sv
tb/sv/tb_top.sv
